/* rtl/b64url_pkg.sv */
// shared types, constants and the character map of the base64url encoder
package b64url_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SEXTET_W = 6;
   localparam int unsigned GROUP_CHARS = 4;
   localparam int unsigned CHAR_IDX_W  = $clog2(GROUP_CHARS);

   // index of the final character of a group
   localparam logic [CHAR_IDX_W-1:0] LAST_IDX_ONE_BYTE   = 2'd1;
   localparam logic [CHAR_IDX_W-1:0] LAST_IDX_TWO_BYTES  = 2'd2;
   localparam logic [CHAR_IDX_W-1:0] LAST_IDX_FULL_GROUP = 2'd3;

   // holding store fill levels
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   // alphabet bounds and characters
   localparam logic [SEXTET_W-1:0] SEXTET_LOWER = 6'd26;
   localparam logic [SEXTET_W-1:0] SEXTET_DIGIT = 6'd52;
   localparam logic [SEXTET_W-1:0] SEXTET_DASH  = 6'd62;
   localparam logic [BYTE_W-1:0]   ASCII_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0]   ASCII_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0]   ASCII_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0]   ASCII_DASH    = 8'h2d;
   localparam logic [BYTE_W-1:0]   ASCII_UNDER   = 8'h5f;

   // one group handed from front to back
   typedef struct packed {
      logic [GROUP_CHARS-1:0][SEXTET_W-1:0] sextets;
      logic [CHAR_IDX_W-1:0]                last_idx;
      logic                                 eom;
   } group_type;

   localparam int unsigned GROUP_W = $bits(group_type);

   function automatic logic [BYTE_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] s);
      logic [BYTE_W-1:0] c;
      c = ASCII_UNDER;
      if (s < SEXTET_LOWER) begin
         c = ASCII_UPPER_A + BYTE_W'(s);
      end else if (s < SEXTET_DIGIT) begin
         c = ASCII_LOWER_A + BYTE_W'(s - SEXTET_LOWER);
      end else if (s < SEXTET_DASH) begin
         c = ASCII_ZERO + BYTE_W'(s - SEXTET_DIGIT);
      end else if (s == SEXTET_DASH) begin
         c = ASCII_DASH;
      end
      return c;
   endfunction

endpackage

/* rtl/b64url_front.sv */
// front end: takes bytes, holds a partial group and splits finished groups into sextets
module b64url_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     req_tlast,
   input  logic                     q_full,
   output logic                     q_push,
   output b64url_pkg::group_type    q_wdata
);
   import b64url_pkg::*;

   logic [1:0]        held_ff, held_in;
   logic [BYTE_W-1:0] pend0_ff, pend0_in;
   logic [BYTE_W-1:0] pend1_ff, pend1_in;
   logic              accept;
   logic [BYTE_W-1:0] b0, b1, b2;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && (req_tlast || (held_ff == HELD_TWO));

   // assemble the group, missing bytes count as zero
   always_comb begin
      b0 = req_tdata;
      b1 = '0;
      b2 = '0;
      q_wdata.last_idx = LAST_IDX_ONE_BYTE;
      unique case (held_ff)
         HELD_TWO: begin
            b0 = pend0_ff;
            b1 = pend1_ff;
            b2 = req_tdata;
            q_wdata.last_idx = LAST_IDX_FULL_GROUP;
         end
         HELD_ONE: begin
            b0 = pend0_ff;
            b1 = req_tdata;
            q_wdata.last_idx = LAST_IDX_TWO_BYTES;
         end
         default: begin
            b0 = req_tdata;
         end
      endcase
      q_wdata.eom        = req_tlast;
      q_wdata.sextets[0] = b0[7:2];
      q_wdata.sextets[1] = {b0[1:0], b1[7:4]};
      q_wdata.sextets[2] = {b1[3:0], b2[7:6]};
      q_wdata.sextets[3] = b2[5:0];
   end

   always_comb begin
      held_in  = held_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (accept) begin
         if (q_push) begin
            held_in = HELD_NONE;
         end else begin
            held_in = held_ff + 2'd1;
            if (held_ff == HELD_NONE) begin
               pend0_in = req_tdata;
            end else begin
               pend1_in = req_tdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
      end else begin
         held_ff <= held_in;
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

/* rtl/b64url_queue.sv */
// small first-in first-out queue of groups between front and back
module b64url_queue #(
   parameter int unsigned DEPTH = b64url_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64url_pkg::group_type wdata,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output b64url_pkg::group_type rdata
);
   import b64url_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign rdata     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/b64url_back.sv */
// back end: head group to output register, one character per cycle unless stalled
module b64url_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  b64url_pkg::group_type q_rdata,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);
   import b64url_pkg::*;

   logic [CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [BYTE_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  advance;
   logic                  at_last;

   assign advance = q_not_empty && (!valid_ff || rsp_tready);
   assign at_last = (idx_ff == q_rdata.last_idx);
   assign q_pop   = advance && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         char_in  = sextet_to_char(q_rdata.sextets[idx_ff]);
         last_in  = q_rdata.eom && at_last;
         idx_in   = at_last ? '0 : idx_ff + CHAR_IDX_W'(1);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

`ifndef ASSERT_OFF
   // the character walk never passes the end of the head group
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      q_not_empty |-> (idx_ff <= q_rdata.last_idx))
      else $error("character index beyond group end");

   // a group leaves the queue only together with its final character
   a_pop_sets_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_tvalid && (idx_ff == '0)))
      else $error("group popped without emitting its final character");

   // a flagged character always closes a group
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && q_rdata.eom && at_last) |=> (rsp_tlast && (idx_ff == '0)))
      else $error("message end not on a group boundary");
`endif

endmodule

/* rtl/base64url_stream_encoder.sv */
// top level of the unpadded base64url stream encoder
//
//  port group  dir  tdata             tlast           role
//  req_*       in   data_byte[7:0]    end_of_message  raw message bytes
//  rsp_*       out  char_code[7:0]    last_char       base64url characters
//
// a byte is taken every cycle while the group queue has room, and the group
// it completes enters the queue at that edge; from the queue its first
// character is loaded into the output register. one character leaves per cycle
// from it while rsp_tready is high and a group is waiting, four per three bytes.
// reset clears the holding count, the queue pointers and the output valid.
// a stalled rsp side fills the queue, then req_tready drops for every byte.
module base64url_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = b64url_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_code
   output logic       rsp_tlast    // last_char
);
   import b64url_pkg::*;

   // queue link between front and back
   group_type q_wdata;
   group_type q_rdata;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_not_empty;

   // front: holding store and group split
   b64url_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // decoupling queue of whole groups
   b64url_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   // back: character serializer with registered output
   b64url_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* tb/tb_base64url_stream_encoder.sv */
// self-checking testbench for the unpadded base64url stream encoder
module tb_base64url_stream_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;   // far above the slowest correct run
   localparam int DRAIN_CYCLES = 20;      // settle time after the last character

   // one expected output character
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } url_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // end_of_message
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] char_code
   logic       rsp_tlast;           // last_char

   // encoder state mirrored by the predictor
   logic [7:0]   held_bytes [2];
   int           held_count;
   url_char_type pending_chars [$];

   string url_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   int send_idle_pct;   // chance per cycle that the sender holds back
   int recv_idle_pct;   // chance per cycle that the receiver stalls
   int hold_left;       // cycles left of a forced receiver stall
   int mismatches;
   int cycle_count;

   base64url_stream_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // work out the characters one accepted byte gives
   function automatic void encode_byte(input logic [7:0] data_byte, input logic eom);
      logic [7:0]   g0, g1, g2;
      logic [5:0]   sextet [4];
      int           n_chars;
      url_char_type c;
      // a byte that leaves a partial group without end only gets held
      if (held_count < 2 && !eom) begin
         held_bytes[held_count] = data_byte;
         held_count++;
         return;
      end
      // missing bytes of a partial group count as zero
      g0 = data_byte;
      g1 = 8'h00;
      g2 = 8'h00;
      n_chars = 2;
      if (held_count == 2) begin
         g0 = held_bytes[0];
         g1 = held_bytes[1];
         g2 = data_byte;
         n_chars = 4;
      end else if (held_count == 1) begin
         g0 = held_bytes[0];
         g1 = data_byte;
         n_chars = 3;
      end
      sextet[0] = g0[7:2];
      sextet[1] = {g0[1:0], g1[7:4]};
      sextet[2] = {g1[3:0], g2[7:6]};
      sextet[3] = g2[5:0];
      for (int k = 0; k < n_chars; k++) begin
         c.char_code = url_alphabet[sextet[k]];
         // only the final character of a message carries last
         c.last_char = eom && (k == n_chars - 1);
         pending_chars.insert(pending_chars.size(), c);
      end
      held_count = 0;
   endfunction

   // receiver: random stalls, or a forced stretch counted down here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each accepted character with the oldest expectation
   always @(posedge clock) begin : check_chars
      url_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected char, expected none, got %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== want.char_code) begin
               $display("%0t: char_code mismatch, expected %h, got %h",
                        $time, want.char_code, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last_char) begin
               $display("%0t: last_char mismatch, expected %b, got %b",
                        $time, want.last_char, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // offer one item, with random gaps before it, and wait for acceptance
   task automatic send_byte(input logic [7:0] data_byte, input logic eom);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data_byte;
      req_tlast  = eom;
      do @(posedge clock); while (!req_tready);
      encode_byte(data_byte, eom);
   endtask

   // one message of random bytes, end flag on its final byte
   task automatic send_message(input int length);
      for (int i = 0; i < length; i++) begin
         send_byte(8'($urandom), i == length - 1);
      end
   endtask

   // sender goes quiet until every expected character is out
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // extremes of the byte, each group shape and the two url-safe characters
   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // one leftover byte, all zeros then all ones
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      // two leftover bytes
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      // full group ending the message, all dashes
      send_byte(8'hfb, 1'b0);
      send_byte(8'hef, 1'b0);
      send_byte(8'hbe, 1'b1);
      // full group without end, all underscores, then one leftover byte
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b1);
      // digits
      send_byte(8'hd3, 1'b0);
      send_byte(8'h5d, 1'b0);
      send_byte(8'hb7, 1'b1);
      // five bytes: a group and two leftover
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'h9a, 1'b1);
      wait_drained();
   endtask

   // random messages, mostly short, a few long
   task automatic test_random_messages(input int budget, input int send_pct,
                                       input int recv_pct);
      int sent;
      int length;
      sent = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < budget) begin
         if ($urandom_range(9) == 0) length = $urandom_range(24, 10);
         else length = $urandom_range(7, 1);
         send_message(length);
         sent += length;
      end
      wait_drained();
   endtask

   // receiver holds off long while the sender keeps offering items
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = 300;
      for (int i = 0; i < 8; i++) begin
         send_message($urandom_range(7, 1));
      end
      wait_drained();
   endtask

   // sender pauses after each message until every character has come
   task automatic test_message_pause();
      send_idle_pct = 0;
      recv_idle_pct = 30;
      for (int i = 0; i < 6; i++) begin
         send_message($urandom_range(6, 1));
         wait_drained();
      end
   endtask

   initial begin
      held_count = 0;
      hold_left = 0;
      mismatches = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // reset held from time zero, released at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_messages(110, 18, 57);
      test_random_messages(110, 57, 18);
      test_random_messages(110, 0, 0);
      test_backpressure();
      test_message_pause();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_chars.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
